// ===== rtl/cts_pkg.sv =====
package cts_pkg;

    // Opcodes of the command channel.
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_DEL   = 3'd1,
        OP_TICK  = 3'd2,
        OP_DISP  = 3'd3,
        OP_QUERY = 3'd4
    } op_e;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    // At most this many tasks are named by one dispatch.
    localparam int MAX_RESULTS = 16;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    // Reciprocal of ten: x / 10 == (x * RECIP10) >> 35 for every 32-bit x.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  task_id;
        logic [31:0] delay_ms;
        logic [31:0] period_ms;
    } cts_in_t;

    typedef struct packed {
        logic [7:0] run_id;
        logic       run_valid;
        logic [1:0] status;
        logic       last;
    } cts_out_t;

    // One table entry.
    typedef struct packed {
        logic [7:0]  task_id;
        logic [28:0] delay;
        logic [28:0] period;
        logic [7:0]  pending;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_D,
        S_DIV_P,
        S_RD,
        S_PROC,
        S_FIN
    } state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_d;
        logic div_p;
        logic rd;
        logic proc;
        logic fin;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic walk_last;
        logic blocked;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/cooperative_task_scheduler.sv =====
// Channel   Signals                     Payload
// command   cmd_valid / cmd_stall       cmd (opcode, task_id, delay_ms, period_ms)
// result    res_valid / res_stall       res (run_id, run_valid, status, last)
//
// A command is dominated by the walk through the task table: each entry takes a
// registered read in S_RD and then an update, with the write-back, in S_PROC.
// Reset clears the task count and the output valid flag; table contents need none.
// A stalled result register holds the walk only when a further result is ready.
module cooperative_task_scheduler
    import cts_pkg::*;
    #(
        parameter int MAX_TASKS = 16
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     cmd_valid,
        output logic     cmd_stall,
        input  cts_in_t  cmd,
        output logic     res_valid,
        input  logic     res_stall,
        output cts_out_t res
    );

    cmd_t  ctl_cmd;
    stat_t dp_st;

    cts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .st        (dp_st),
        .cmd       (ctl_cmd)
    );

    cts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd),
        .cmd       (ctl_cmd),
        .st        (dp_st),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/cts_ram.sv =====
module cts_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        parameter int AW    = 4
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cts_ctrl.sv =====
module cts_ctrl
    import cts_pkg::*;
    (
        input  logic  clk,
        input  logic  rst_n,
        input  logic  cmd_valid,
        output logic  cmd_stall,
        input  stat_t st,
        output cmd_t  cmd
    );

    state_e state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV_D;
                end
            end
            S_DIV_D:
            begin
                cmd.div_d  = 1'b1;
                state_next = S_DIV_P;
            end
            S_DIV_P:
            begin
                cmd.div_p  = 1'b1;
                state_next = st.count_zero ? S_FIN : S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PROC;
            end
            S_PROC:
            begin
                if (!st.blocked)
                begin
                    cmd.proc   = 1'b1;
                    state_next = st.walk_last ? S_FIN : S_RD;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cts_dp.sv =====
module cts_dp
    import cts_pkg::*;
    #(
        parameter int MAX_TASKS = 16
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  cts_in_t  cmd_data,
        input  cmd_t     cmd,
        output stat_t    st,
        output logic     res_valid,
        input  logic     res_stall,
        output cts_out_t res
    );

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = $bits(entry_t);

    logic [2:0]  op_reg;
    logic [7:0]  id_reg;
    logic [31:0] dms_reg, pms_reg;
    logic [28:0] dly_reg, per_reg;
    logic [CW-1:0] r_reg, w_reg, count_reg;
    logic [NW-1:0] n_reg;
    logic        found_reg, held_valid_reg;
    logic [7:0]  held_id_reg;
    logic        out_valid_reg;
    cts_out_t    out_reg;

    entry_t      rd_ent, new_ent;
    logic        keep, emit, match, push, out_free;
    logic [31:0] div_in;
    logic [63:0] prod;
    logic        we;
    logic [IW-1:0] waddr;
    entry_t      wdata;
    cts_out_t    push_data;
    logic        add_ok;
    logic [EW-1:0] rdata_raw;

    cts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS), .AW(IW)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (r_reg[IW-1:0]),
        .rdata (rdata_raw)
    );

    assign rd_ent = entry_t'(rdata_raw);

    // Divide by ten through the reciprocal; one multiply per cycle.
    assign div_in = cmd.div_p ? pms_reg : dms_reg;
    assign prod   = {32'd0, div_in} * {32'd0, RECIP10};

    // Per-entry update of the walk.
    always_comb
    begin
        new_ent = rd_ent;
        keep    = 1'b1;
        emit    = 1'b0;
        match   = (rd_ent.task_id == id_reg);
        case (op_reg)
            OP_TICK:
            begin
                if (rd_ent.delay != '0)
                begin
                    new_ent.delay = rd_ent.delay - 29'd1;
                end
                else
                begin
                    if (rd_ent.pending != 8'hFF)
                    begin
                        new_ent.pending = rd_ent.pending + 8'd1;
                    end
                    new_ent.delay = rd_ent.period;
                end
            end
            OP_DISP:
            begin
                if (rd_ent.pending != 8'd0 && n_reg < NW'(MAX_RESULTS))
                begin
                    emit            = 1'b1;
                    new_ent.pending = rd_ent.pending - 8'd1;
                    if (rd_ent.period == '0)
                    begin
                        keep = 1'b0;
                    end
                end
            end
            OP_DEL:
            begin
                if (match)
                begin
                    keep = 1'b0;
                end
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !res_stall;
    assign add_ok   = (op_reg == OP_ADD) && !found_reg && (w_reg != CW'(MAX_TASKS));

    assign st.count_zero = (count_reg == '0);
    assign st.walk_last  = ((r_reg + CW'(1)) == count_reg);
    assign st.blocked    = emit && held_valid_reg && !out_free;
    assign st.out_free   = out_free;

    // Table write: compaction during the walk, append at the end of an add.
    always_comb
    begin
        we    = 1'b0;
        waddr = w_reg[IW-1:0];
        wdata = new_ent;
        if (cmd.proc && keep)
        begin
            we = 1'b1;
        end
        else if (cmd.fin && add_ok)
        begin
            we    = 1'b1;
            wdata = '{task_id: id_reg, delay: dly_reg, period: per_reg, pending: 8'd0};
        end
    end

    // Result to transfer to the output register.
    always_comb
    begin
        push      = 1'b0;
        push_data = '{run_id: id_reg, run_valid: 1'b0, status: ST_NONE, last: 1'b1};
        if (cmd.proc && emit && held_valid_reg)
        begin
            push      = 1'b1;
            push_data = '{run_id: held_id_reg, run_valid: 1'b1, status: ST_OK, last: 1'b0};
        end
        else if (cmd.fin)
        begin
            push = 1'b1;
            case (op_reg)
                OP_ADD:
                begin
                    if (found_reg)
                    begin
                        push_data.status = ST_DUP;
                    end
                    else if (!add_ok)
                    begin
                        push_data.status = ST_FULL;
                    end
                    else
                    begin
                        push_data.status = ST_OK;
                    end
                end
                OP_DEL, OP_QUERY:
                begin
                    push_data.status = found_reg ? ST_OK : ST_NONE;
                end
                OP_TICK:
                begin
                    push_data.run_id = 8'd0;
                    push_data.status = ST_OK;
                end
                OP_DISP:
                begin
                    if (held_valid_reg)
                    begin
                        push_data.run_id    = held_id_reg;
                        push_data.run_valid = 1'b1;
                        push_data.status    = ST_OK;
                    end
                    else
                    begin
                        push_data.run_id = 8'd0;
                    end
                end
                default:
                begin
                    push_data.status = ST_NONE;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            r_reg          <= '0;
            w_reg          <= '0;
            n_reg          <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                r_reg          <= '0;
                w_reg          <= '0;
                n_reg          <= '0;
                found_reg      <= 1'b0;
                held_valid_reg <= 1'b0;
            end
            if (cmd.proc)
            begin
                r_reg <= r_reg + CW'(1);
                if (keep)
                begin
                    w_reg <= w_reg + CW'(1);
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                if (emit)
                begin
                    held_valid_reg <= 1'b1;
                    n_reg          <= n_reg + NW'(1);
                end
            end
            if (cmd.fin)
            begin
                count_reg <= add_ok ? (w_reg + CW'(1)) : w_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= cmd_data.opcode;
            id_reg  <= cmd_data.task_id;
            dms_reg <= cmd_data.delay_ms;
            pms_reg <= cmd_data.period_ms;
        end
        if (cmd.div_d)
        begin
            dly_reg <= prod[63:35];
        end
        if (cmd.div_p)
        begin
            per_reg <= prod[63:35];
        end
        if (cmd.proc && emit)
        begin
            held_id_reg <= rd_ent.task_id;
        end
        if (push)
        begin
            out_reg <= push_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== dv/tb.sv =====
module tb;
    import cts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 20000;

    // Scheduler predictor and the queue of results it expects.
    class sched_scoreboard;
        logic [7:0]  ids[TABLE_DEPTH];
        logic [28:0] delays[TABLE_DEPTH];
        logic [28:0] periods[TABLE_DEPTH];
        logic [7:0]  pending[TABLE_DEPTH];
        int          count;
        cts_out_t    due[$];
        int          errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int find_id(logic [7:0] id);
            for (int i = 0; i < count; i++)
            begin
                if (ids[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function void drop(int pos);
            for (int i = pos; i + 1 < count; i++)
            begin
                ids[i]     = ids[i + 1];
                delays[i]  = delays[i + 1];
                periods[i] = periods[i + 1];
                pending[i] = pending[i + 1];
            end
            count--;
        endfunction

        function void push(logic [7:0] id, logic v, logic [1:0] st, logic l);
            cts_out_t r;
            r.run_id    = id;
            r.run_valid = v;
            r.status    = st;
            r.last      = l;
            due.push_back(r);
        endfunction

        // Apply one accepted command and queue the results it causes.
        function void note_command(cts_in_t c);
            int pos;
            int n;
            int i;
            case (c.opcode)
                OP_ADD:
                begin
                    if (find_id(c.task_id) >= 0)
                        push(c.task_id, 1'b0, ST_DUP, 1'b1);
                    else if (count >= TABLE_DEPTH)
                        push(c.task_id, 1'b0, ST_FULL, 1'b1);
                    else
                    begin
                        ids[count]     = c.task_id;
                        delays[count]  = 29'(c.delay_ms / 32'd10);
                        periods[count] = 29'(c.period_ms / 32'd10);
                        pending[count] = 8'd0;
                        count++;
                        push(c.task_id, 1'b0, ST_OK, 1'b1);
                    end
                end
                OP_DEL:
                begin
                    pos = find_id(c.task_id);
                    if (pos < 0)
                        push(c.task_id, 1'b0, ST_NONE, 1'b1);
                    else
                    begin
                        drop(pos);
                        push(c.task_id, 1'b0, ST_OK, 1'b1);
                    end
                end
                OP_TICK:
                begin
                    for (i = 0; i < count; i++)
                    begin
                        if (delays[i] != 0)
                            delays[i]--;
                        else
                        begin
                            if (pending[i] != 8'hFF)
                                pending[i]++;
                            delays[i] = periods[i];
                        end
                    end
                    push(8'd0, 1'b0, ST_OK, 1'b1);
                end
                OP_DISP:
                begin
                    n = 0;
                    i = 0;
                    while (i < count && n < MAX_RESULTS)
                    begin
                        if (pending[i] != 0)
                        begin
                            pending[i]--;
                            push(ids[i], 1'b1, ST_OK, 1'b0);
                            n++;
                            if (periods[i] == 0)
                            begin
                                drop(i);
                                continue;
                            end
                        end
                        i++;
                    end
                    if (n == 0)
                        push(8'd0, 1'b0, ST_NONE, 1'b1);
                    else
                        due[$].last = 1'b1;
                end
                OP_QUERY:
                begin
                    push(c.task_id, 1'b0,
                         (find_id(c.task_id) >= 0) ? ST_OK : ST_NONE, 1'b1);
                end
                default:
                    push(c.task_id, 1'b0, ST_NONE, 1'b1);
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(cts_out_t r);
            cts_out_t e;
            if (due.size() == 0)
            begin
                report("unexpected run_id", r.run_id, 8'd0);
                return;
            end
            e = due.pop_front();
            if (r.run_id !== e.run_id)
                report("run_id", r.run_id, e.run_id);
            if (r.run_valid !== e.run_valid)
                report("run_valid", r.run_valid, e.run_valid);
            if (r.status !== e.status)
                report("status", r.status, e.status);
            if (r.last !== e.last)
                report("last", r.last, e.last);
        endfunction

        function void report(string field, logic [7:0] got, logic [7:0] want);
            errors++;
            $display("ERROR: %s got %0h expected %0h", field, got, want);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    cts_in_t  cmd;
    logic     res_valid;
    logic     res_stall;
    cts_out_t res;

    sched_scoreboard sb;
    int  idle_cycles;
    bit  calm;

    cooperative_task_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Observe transfers at the rising edge and run the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd);
            if (res_valid && !res_stall)
                sb.check_result(res);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver stalls at random, except during the calm stretch.
    always @(negedge clk)
    begin
        if (!calm && $urandom_range(0, 99) < 18)
            res_stall <= 1'b1;
        else
            res_stall <= 1'b0;
    end

    // Send one command and hold it until the transfer completes. Valid stays
    // high on return so that back-to-back commands need no gap.
    task automatic send(logic [2:0] op, logic [7:0] id, logic [31:0] d, logic [31:0] p);
        while (!calm && $urandom_range(0, 99) < 18)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid     <= 1'b1;
        cmd.opcode    <= op;
        cmd.task_id   <= id;
        cmd.delay_ms  <= d;
        cmd.period_ms <= p;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_ms();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(0, 60);
            2:       return $urandom;
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    initial
    begin
        logic [7:0] id;
        int r;
        sb = new();
        idle_cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        res_stall = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, duplicates, invalid opcodes, sole delete, full table, one-shot.
        send(OP_DISP, 8'd0, 32'd0, 32'd0);
        send(OP_DEL, 8'd7, 32'd0, 32'd0);
        send(OP_QUERY, 8'hFF, 32'd0, 32'd0);
        send(OP_ADD, 8'd0, 32'd0, 32'd9);
        send(OP_DEL, 8'd0, 32'd0, 32'd0);
        send(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_ADD, 8'hFF, 32'd0, 32'd0);
        send(OP_QUERY, 8'hFF, 32'd0, 32'd0);
        send(3'd5, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(3'd7, 8'h5A, 32'd0, 32'd0);
        send(OP_DEL, 8'hFF, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send(OP_ADD, 8'(i + 1), 32'd0, (i % 2) ? 32'd10 : 32'd0);
        send(OP_TICK, 8'd0, 32'd0, 32'd0);
        send(OP_DISP, 8'd0, 32'd0, 32'd0);
        send(OP_DISP, 8'd0, 32'd0, 32'd0);

        // One-shot tasks that are due at every tick saturate their pending counts.
        for (int i = 0; i < 8; i++)
            send(OP_ADD, 8'(2 * i + 1), 32'd0, 32'd0);
        calm = 1'b1;
        repeat (260) send(OP_TICK, 8'd0, 32'd0, 32'd0);
        calm = 1'b0;
        send(OP_DISP, 8'd0, 32'd0, 32'd0);

        // Pause the sender until the block has caught up.
        drain();
        for (int i = 0; i < 16; i++)
            send(OP_DEL, 8'(i + 1), 32'd0, 32'd0);

        // Random: mostly small ids, a mix of adds, deletes, ticks, dispatches, queries and invalid opcodes.
        for (int n = 0; n < 90; n++)
        begin
            calm = (n >= 30 && n < 50);
            r = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
            if (r < 25)
                send(OP_ADD, id, rand_ms(), rand_ms());
            else if (r < 35)
                send(OP_DEL, id, $urandom, $urandom);
            else if (r < 65)
                send(OP_TICK, 8'($urandom), $urandom, $urandom);
            else if (r < 85)
                send(OP_DISP, 8'($urandom), $urandom, $urandom);
            else if (r < 95)
                send(OP_QUERY, id, $urandom, $urandom);
            else
                send(3'($urandom_range(5, 7)), 8'($urandom), $urandom, $urandom);
        end
        calm = 1'b0;

        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/cts_pkg.sv
rtl/cts_ram.sv
rtl/cts_ctrl.sv
rtl/cts_dp.sv
rtl/cooperative_task_scheduler.sv
dv/tb.sv
